>>> hw/rtl/frrc_pkg.sv
// frrc_pkg: shared types, codes, reset values and the RRC coefficient table
// for the 4FSK RRC modulator. No dependencies.
package frrc_pkg;

   localparam int SYM_W         = 16;  // symbol level, signed
   localparam int LEVEL_W       = 15;  // level magnitude register, unsigned
   localparam int SAMPLE_W      = 16;  // q15 output sample
   localparam int COEF_W        = 16;
   localparam int PROD_W        = SYM_W + COEF_W;
   localparam int Q_SHIFT       = 15;
   localparam int SYMS_PER_ITEM = 4;
   localparam int COEF_COUNT    = 45;
   localparam int COEF_IDX_W    = 9;   // covers UPSAMPLE*TAPS_PER_PHASE up to 512
   localparam int CSR_IDX_W     = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_OUTER = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_INNER = 8'd1;

   localparam logic [LEVEL_W-1:0] LEVEL_OUTER_RST = 15'd1481;
   localparam logic [LEVEL_W-1:0] LEVEL_INNER_RST = 15'd494;

   // dibit codes
   localparam logic [1:0] DIBIT_POS_OUTER = 2'b11;
   localparam logic [1:0] DIBIT_POS_INNER = 2'b10;
   localparam logic [1:0] DIBIT_NEG_INNER = 2'b00;
   localparam logic [1:0] DIBIT_NEG_OUTER = 2'b01;

   typedef logic signed [SYM_W-1:0] sym_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] outer;
      logic [LEVEL_W-1:0] inner;
   } levels_type;

   // sideband traveling with each sample down the pipe
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   function automatic sym_type dibit_level(input logic [1:0] dibit, input levels_type lv);
      sym_type pos_outer;
      sym_type pos_inner;
      sym_type res;
      pos_outer = sym_type'({1'b0, lv.outer});
      pos_inner = sym_type'({1'b0, lv.inner});
      unique case (dibit)
         DIBIT_POS_OUTER: res = pos_outer;
         DIBIT_POS_INNER: res = pos_inner;
         DIBIT_NEG_INNER: res = -pos_inner;
         DIBIT_NEG_OUTER: res = -pos_outer;
         default:         res = '0;
      endcase
      return res;
   endfunction

   // root-raised-cosine taps, time-reversed order; beyond the table reads zero
   function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      unique case (idx)
         9'd4:  c = -16'sd290;
         9'd5:  c = -16'sd174;
         9'd6:  c = 16'sd142;
         9'd7:  c = 16'sd432;
         9'd8:  c = 16'sd438;
         9'd9:  c = 16'sd90;
         9'd10: c = -16'sd387;
         9'd11: c = -16'sd561;
         9'd12: c = -16'sd155;
         9'd13: c = 16'sd658;
         9'd14: c = 16'sd1225;
         9'd15: c = 16'sd767;
         9'd16: c = -16'sd980;
         9'd17: c = -16'sd3326;
         9'd18: c = -16'sd4648;
         9'd19: c = -16'sd3062;
         9'd20: c = 16'sd2527;
         9'd21: c = 16'sd11552;
         9'd22: c = 16'sd21705;
         9'd23: c = 16'sd29724;
         9'd24: c = 16'sd32767;
         9'd25: c = 16'sd29724;
         9'd26: c = 16'sd21705;
         9'd27: c = 16'sd11552;
         9'd28: c = 16'sd2527;
         9'd29: c = -16'sd3062;
         9'd30: c = -16'sd4648;
         9'd31: c = -16'sd3326;
         9'd32: c = -16'sd980;
         9'd33: c = 16'sd767;
         9'd34: c = 16'sd1225;
         9'd35: c = 16'sd658;
         9'd36: c = -16'sd155;
         9'd37: c = -16'sd561;
         9'd38: c = -16'sd387;
         9'd39: c = 16'sd90;
         9'd40: c = 16'sd438;
         9'd41: c = 16'sd432;
         9'd42: c = 16'sd142;
         9'd43: c = -16'sd174;
         9'd44: c = -16'sd290;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/frrc_if.sv
// frrc_if: valid/ready channel interfaces for the 4FSK RRC modulator.
// No dependencies.
interface frrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       silence;

   modport source (output valid, output data_byte, output silence, input ready);
   modport sink   (input valid, input data_byte, input silence, output ready);
endinterface

interface frrc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

>>> hw/rtl/fourfsk_rrc_modulator_top.sv
// fourfsk_rrc_modulator_top: 4FSK symbol mapper with an x UPSAMPLE polyphase
// root-raised-cosine interpolator. Depends on frrc_pkg, frrc_if, frrc_seq, frrc_mac.
//
//   channel  dir  beat contents            handshake
//   req_chan in   data_byte, silence       valid/ready
//   rsp_chan out  sample (q15), last       valid/ready
//   csr_*    in   csr_index, csr_wdata     csr_we, no back-pressure
//
// One input beat yields 4*UPSAMPLE output beats (20 by default), one per cycle
// while rsp_chan.ready does not hold the pipe. A one-beat input buffer takes the
// next item while the current one is still being sequenced. A sample passes the
// sequencer, product, sum and output registers in that order.
// Synchronous active-high reset clears the symbol window and valids and sets the
// level registers (outer 1481, inner 494).
// rsp_chan.ready low while a beat waits freezes sequencer and MAC; no beat is dropped or repeated.
module fourfsk_rrc_modulator_top #(
   parameter int UPSAMPLE       = 5,
   parameter int TAPS_PER_PHASE = 9
) (
   input  logic                                  clock,
   input  logic                                  reset,
   frrc_req_if.sink                              req_chan,
   frrc_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [frrc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [frrc_pkg::LEVEL_W-1:0]          csr_wdata
);

   localparam int PH_W = $clog2(UPSAMPLE);

   frrc_pkg::levels_type                   levels_ff;
   frrc_pkg::tag_type                      tag_a, tag_c;
   logic [PH_W-1:0]                        phase_a;
   frrc_pkg::sym_type [TAPS_PER_PHASE-1:0] window;
   logic signed [frrc_pkg::SAMPLE_W-1:0]   sample;

   logic                                   out_valid_ff;
   logic                                   out_last_ff;
   logic signed [frrc_pkg::SAMPLE_W-1:0]   out_sample_ff;
   logic                                   en;

   // sequencer and MAC advance whenever the output register can take a beat
   assign en = !out_valid_ff || rsp_chan.ready;

   // level registers
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff.outer <= frrc_pkg::LEVEL_OUTER_RST;
         levels_ff.inner <= frrc_pkg::LEVEL_INNER_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            frrc_pkg::REG_LEVEL_OUTER: levels_ff.outer <= csr_wdata;
            frrc_pkg::REG_LEVEL_INNER: levels_ff.inner <= csr_wdata;
            default: ;  // unknown index: ignored
         endcase
      end
   end

   frrc_seq #(
      .UPSAMPLE       (UPSAMPLE),
      .TAPS_PER_PHASE (TAPS_PER_PHASE)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .req_chan (req_chan),
      .levels   (levels_ff),
      .tag_a    (tag_a),
      .phase_a  (phase_a),
      .window   (window)
   );

   frrc_mac #(
      .UPSAMPLE       (UPSAMPLE),
      .TAPS_PER_PHASE (TAPS_PER_PHASE)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .tag_a   (tag_a),
      .phase_a (phase_a),
      .window  (window),
      .tag_c   (tag_c),
      .sample  (sample)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= tag_c.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && tag_c.valid) begin
         out_sample_ff <= sample;
         out_last_ff   <= tag_c.last;
      end
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.sample = out_sample_ff;
   assign rsp_chan.last   = out_last_ff;

   // buffer holds one beat: an accepted beat closes the input until it moves on
   a_buf_full: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input buffer took a second beat");

   // a finished sample always lands in the output register
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (en && tag_c.valid) |=> out_valid_ff)
      else $error("sample lost before output register");

   // a stall freezes the pipe tail
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(tag_c))
      else $error("pipe moved during stall");

   // last only rides on a valid sample
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      tag_c.last |-> tag_c.valid)
      else $error("last tag without sample");

endmodule

>>> hw/rtl/frrc_seq.sv
// frrc_seq: input beat buffer, symbol/phase sequencer, level mapping and the
// symbol window. Depends on frrc_pkg and frrc_if.
module frrc_seq #(
   parameter int UPSAMPLE       = 5,
   parameter int TAPS_PER_PHASE = 9
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   frrc_req_if.sink                                 req_chan,
   input  frrc_pkg::levels_type                     levels,
   output frrc_pkg::tag_type                        tag_a,
   output logic [$clog2(UPSAMPLE)-1:0]              phase_a,
   output frrc_pkg::sym_type [TAPS_PER_PHASE-1:0]   window
);

   localparam int PH_W = $clog2(UPSAMPLE);

   // one-beat input buffer
   logic       buf_valid_ff, buf_valid_in;
   logic [7:0] buf_byte_ff;
   logic       buf_silence_ff;

   // item being sequenced
   logic            seq_valid_ff, seq_valid_in;
   logic [7:0]      seq_byte_ff;
   logic            seq_silence_ff;
   logic [1:0]      sym_ff, sym_in;
   logic [PH_W-1:0] phase_ff, phase_in;

   frrc_pkg::sym_type [TAPS_PER_PHASE-1:0] window_ff, window_in;
   frrc_pkg::tag_type                      tag_ff;
   logic [PH_W-1:0]                        phase_a_ff;

   logic              accept, issue, finish, load, phase_end;
   logic [1:0]        dibit;
   frrc_pkg::sym_type level;

   assign req_chan.ready = !buf_valid_ff;
   assign accept    = req_chan.valid && req_chan.ready;
   assign issue     = en && seq_valid_ff;
   assign phase_end = (phase_ff == PH_W'(UPSAMPLE - 1));
   assign finish    = phase_end && (sym_ff == 2'(frrc_pkg::SYMS_PER_ITEM - 1));
   assign load      = en && buf_valid_ff && (!seq_valid_ff || finish);

   always_comb begin
      unique case (sym_ff)
         2'd0:    dibit = seq_byte_ff[7:6];
         2'd1:    dibit = seq_byte_ff[5:4];
         2'd2:    dibit = seq_byte_ff[3:2];
         default: dibit = seq_byte_ff[1:0];
      endcase
      level = seq_silence_ff ? '0 : frrc_pkg::dibit_level(dibit, levels);
   end

   always_comb begin
      buf_valid_in = buf_valid_ff;
      if (accept) begin
         buf_valid_in = 1'b1;
      end else if (load) begin
         buf_valid_in = 1'b0;
      end

      seq_valid_in = seq_valid_ff;
      sym_in       = sym_ff;
      phase_in     = phase_ff;
      if (load) begin
         seq_valid_in = 1'b1;
         sym_in       = '0;
         phase_in     = '0;
      end else if (issue) begin
         if (finish) begin
            seq_valid_in = 1'b0;
         end
         if (phase_end) begin
            phase_in = '0;
            sym_in   = sym_ff + 2'd1;
         end else begin
            phase_in = phase_ff + PH_W'(1);
         end
      end

      // new symbol slides in on its first phase
      window_in = window_ff;
      if (issue && (phase_ff == '0)) begin
         for (int k = 0; k < TAPS_PER_PHASE - 1; k++) begin
            window_in[k] = window_ff[k + 1];
         end
         window_in[TAPS_PER_PHASE - 1] = level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         seq_valid_ff <= 1'b0;
         sym_ff       <= '0;
         phase_ff     <= '0;
         window_ff    <= '0;
         tag_ff       <= '0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         seq_valid_ff <= seq_valid_in;
         sym_ff       <= sym_in;
         phase_ff     <= phase_in;
         window_ff    <= window_in;
         if (en) begin
            tag_ff.valid <= issue;
            tag_ff.last  <= issue && finish;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_byte_ff    <= req_chan.data_byte;
         buf_silence_ff <= req_chan.silence;
      end
      if (load) begin
         seq_byte_ff    <= buf_byte_ff;
         seq_silence_ff <= buf_silence_ff;
      end
      if (en) begin
         phase_a_ff <= phase_ff;
      end
   end

   assign tag_a   = tag_ff;
   assign phase_a = phase_a_ff;
   assign window  = window_ff;

endmodule

>>> hw/rtl/frrc_mac.sv
// frrc_mac: polyphase tap products, registered sum, floor shift and q15
// saturation. Depends on frrc_pkg.
module frrc_mac #(
   parameter int UPSAMPLE       = 5,
   parameter int TAPS_PER_PHASE = 9
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  frrc_pkg::tag_type                        tag_a,
   input  logic [$clog2(UPSAMPLE)-1:0]              phase_a,
   input  frrc_pkg::sym_type [TAPS_PER_PHASE-1:0]   window,
   output frrc_pkg::tag_type                        tag_c,
   output logic signed [frrc_pkg::SAMPLE_W-1:0]     sample
);

   localparam int IDX_W  = $clog2(UPSAMPLE * TAPS_PER_PHASE);
   localparam int ACC_W  = frrc_pkg::PROD_W + $clog2(TAPS_PER_PHASE);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

   logic signed [frrc_pkg::PROD_W-1:0] prod_ff [TAPS_PER_PHASE];
   logic signed [frrc_pkg::PROD_W-1:0] prod_in [TAPS_PER_PHASE];
   logic [IDX_W-1:0]                   idx [TAPS_PER_PHASE];
   frrc_pkg::tag_type                  tag_b_ff, tag_c_ff;
   logic signed [ACC_W-1:0]            sum_ff, sum_in, shifted;

   for (genvar k = 0; k < TAPS_PER_PHASE; k++) begin : g_tap
      logic signed [frrc_pkg::COEF_W-1:0] coef;
      assign idx[k]     = IDX_W'(UPSAMPLE - 1) - IDX_W'(phase_a) + IDX_W'(k * UPSAMPLE);
      assign coef       = frrc_pkg::coef_at(frrc_pkg::COEF_IDX_W'(idx[k]));
      assign prod_in[k] = $signed(window[k]) * coef;
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < TAPS_PER_PHASE; k++) begin
         sum_in = sum_in + ACC_W'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_b_ff <= '0;
         tag_c_ff <= '0;
      end else if (en) begin
         tag_b_ff <= tag_a;
         tag_c_ff <= tag_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   // arithmetic shift rounds toward minus infinity
   assign shifted = sum_ff >>> frrc_pkg::Q_SHIFT;

   always_comb begin
      priority if (shifted > SAT_HI) begin
         sample = 16'sh7FFF;
      end else if (shifted < SAT_LO) begin
         sample = 16'sh8000;
      end else begin
         sample = shifted[frrc_pkg::SAMPLE_W-1:0];
      end
   end

   assign tag_c = tag_c_ff;

endmodule
